// File: hw/rtl/erp_pkg.sv
// Encoder reply parser package: transfer types, character codes, status codes.
// No dependencies; imported by every module of the parser.
package erp_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 9;
  localparam int unsigned ACC_W          = 40;
  localparam int unsigned POS_W          = 3;

  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_EQUAL = 8'd61;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  // Header check happens on this byte of the frame
  localparam logic [POS_W-1:0] HDR_EQ_POS = 3'd4;
  localparam logic [POS_W-1:0] SIGN1_POS  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_TOO_MANY   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SIGN1,
    PH_DIGITS1,
    PH_SIGN2,
    PH_DIGITS2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_count;
    logic signed [31:0] second_count;
    logic [1:0]         status;
  } out_item_t;

endpackage

// File: hw/rtl/erp_in_stage.sv
// Input register of the encoder reply parser.
// Depends on erp_pkg for the input transfer type.
module erp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  erp_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              s1_valid,
  output erp_pkg::in_item_t s1_item
);
  import erp_pkg::*;

  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     accept;

  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// File: hw/rtl/erp_parse.sv
// Frame parser state and digit accumulators of the encoder reply parser.
// Depends on erp_pkg for phases, character codes and transfer types.
module erp_parse #(
  parameter int unsigned MAX_DIGITS = erp_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  erp_pkg::in_item_t  item,
  output logic               res_valid,
  output erp_pkg::out_item_t res
);
  import erp_pkg::*;

  localparam int unsigned DCW = $clog2(MAX_DIGITS + 1);
  localparam logic [DCW-1:0] DMAX = DCW'(MAX_DIGITS);

  phase_t                  phase_r, phase_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    neg1_r, neg1_nxt;
  logic                    neg2_r, neg2_nxt;
  logic signed [ACC_W-1:0] acc1_r, acc1_nxt;
  logic signed [ACC_W-1:0] acc2_r, acc2_nxt;
  logic [DCW-1:0]          dcnt_r, dcnt_nxt;

  logic                    is_minus, is_colon, is_cr, is_eq, dig_full;
  logic [POS_W-1:0]        pos_inc;
  logic signed [ACC_W-1:0] dig_val, acc1_up, acc2_up;
  logic                    emit;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] acc,
                                               input logic neg);
    logic signed [ACC_W-1:0] v;
    v = neg ? -acc : acc;
    if (v > ACC_W'(64'sd2147483647)) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -(ACC_W'(64'sd2147483648))) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign is_minus = item.rx_byte == CH_MINUS;
  assign is_colon = item.rx_byte == CH_COLON;
  assign is_cr    = item.rx_byte == CH_CR;
  assign is_eq    = item.rx_byte == CH_EQUAL;
  assign dig_full = dcnt_r >= DMAX;
  assign pos_inc  = pos_r + 1'b1;

  // Any byte in a digit slot counts, even a non-numeric one
  assign dig_val = $signed({{(ACC_W-8){1'b0}}, item.rx_byte})
                 - $signed({{(ACC_W-8){1'b0}}, CH_ZERO});
  assign acc1_up = (acc1_r <<< 3) + (acc1_r <<< 1) + dig_val;
  assign acc2_up = (acc2_r <<< 3) + (acc2_r <<< 1) + dig_val;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.frame_start) begin
      phase_nxt = PH_HEADER;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_inc == HDR_EQ_POS) begin
            phase_nxt = is_eq ? PH_SIGN1 : PH_IDLE;
          end
        end
        PH_SIGN1: begin
          if (is_minus) begin
            phase_nxt = PH_DIGITS1;
          end else if (is_colon) begin
            phase_nxt = PH_SIGN2;
          end else begin
            phase_nxt = dig_full ? PH_IDLE : PH_DIGITS1;
          end
        end
        PH_DIGITS1: begin
          if (is_colon) begin
            phase_nxt = PH_SIGN2;
          end else if (dig_full) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_SIGN2: begin
          if (is_minus) begin
            phase_nxt = PH_DIGITS2;
          end else if (is_cr || dig_full) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_DIGITS2;
          end
        end
        PH_DIGITS2: begin
          if (is_cr || dig_full) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    pos_nxt          = pos_r;
    neg1_nxt         = neg1_r;
    neg2_nxt         = neg2_r;
    acc1_nxt         = acc1_r;
    acc2_nxt         = acc2_r;
    dcnt_nxt         = dcnt_r;
    emit             = 1'b0;
    res.first_count  = '0;
    res.second_count = '0;
    res.status       = ST_OK;
    if (item.frame_start) begin
      pos_nxt  = '0;
      neg1_nxt = 1'b0;
      neg2_nxt = 1'b0;
      acc1_nxt = '0;
      acc2_nxt = '0;
      dcnt_nxt = '0;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          pos_nxt = pos_inc;
          if (pos_inc == HDR_EQ_POS) begin
            if (!is_eq) begin
              emit       = 1'b1;
              res.status = ST_BAD_HEADER;
            end else begin
              dcnt_nxt = '0;
            end
          end
        end
        PH_SIGN1, PH_DIGITS1: begin
          if (phase_r == PH_SIGN1) begin
            pos_nxt = SIGN1_POS;
          end
          if (phase_r == PH_SIGN1 && is_minus) begin
            neg1_nxt = 1'b1;
          end else if (is_colon) begin
            dcnt_nxt = '0;
          end else if (dig_full) begin
            emit       = 1'b1;
            res.status = ST_TOO_MANY;
          end else begin
            acc1_nxt = acc1_up;
            dcnt_nxt = dcnt_r + 1'b1;
          end
        end
        PH_SIGN2, PH_DIGITS2: begin
          if (phase_r == PH_SIGN2 && is_minus) begin
            neg2_nxt = 1'b1;
          end else if (is_cr) begin
            emit             = 1'b1;
            res.first_count  = sat32(acc1_r, neg1_r);
            res.second_count = sat32(acc2_r, neg2_r);
          end else if (dig_full) begin
            emit       = 1'b1;
            res.status = ST_TOO_MANY;
          end else begin
            acc2_nxt = acc2_up;
            dcnt_nxt = dcnt_r + 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      neg1_r  <= 1'b0;
      neg2_r  <= 1'b0;
      acc1_r  <= '0;
      acc2_r  <= '0;
      dcnt_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      neg1_r  <= neg1_nxt;
      neg2_r  <= neg2_nxt;
      acc1_r  <= acc1_nxt;
      acc2_r  <= acc2_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

// File: hw/rtl/erp_out_stage.sv
// Result register of the encoder reply parser.
// Depends on erp_pkg for the result transfer type.
module erp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  erp_pkg::out_item_t res,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output erp_pkg::out_item_t out_data
);
  import erp_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;

  // Register is free when empty or being taken this cycle
  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/encoder_reply_parser.sv
// Encoder reply parser top level: input register, frame parser, result register.
// Depends on erp_pkg, erp_in_stage, erp_parse and erp_out_stage.
//
//   channel  | ports                          | carries
//   ---------+--------------------------------+-------------------------------------
//   input    | in_valid, in_stall, in_data    | one reply byte plus frame start mark
//   result   | out_valid, out_stall, out_data | two saturated counts plus status
//
// One byte per clock is taken while the result side does not stall; a byte passes
// through the input register and is then parsed into the result register.
// A result appears only for the closing CR, a bad header or a digit overflow.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to idle, so bytes are ignored until the next frame start.
// A stall on the result side holds the result register; the input side then
// stalls only while its own register is also full.
module encoder_reply_parser #(
  parameter int unsigned MAX_DIGITS = erp_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  erp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output erp_pkg::out_item_t out_data
);
  import erp_pkg::*;

  logic      advance;      // result register can take a new value
  logic      s1_valid;     // byte waiting in the input register
  in_item_t  s1_item;
  logic      res_valid;    // parser produces a result this cycle
  out_item_t res;

  erp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Parser state moves only when the byte can leave the input register
  erp_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid && advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  erp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for encoder_reply_parser: directed and random reply frames.
// A built-in parser predictor checks every result transfer in order.
// Depends on erp_pkg and the encoder_reply_parser RTL only.
`timescale 1ns / 100ps

module tb_top;
  import erp_pkg::*;

  localparam int     DIGIT_LIMIT  = MAX_DIGITS_DEF;
  localparam longint COUNT_MAX    = 64'sd2147483647;
  localparam longint COUNT_MIN    = -64'sd2147483648;
  localparam int     FRAME_ITEMS  = 1300;
  localparam int     DRAIN_LIMIT  = 5000;
  localparam int     REPORT_LIMIT = 50;

  // How the digit bytes of a random number are drawn
  typedef enum int {
    DS_DECIMAL,   // '0'..'9' only
    DS_ANY,       // any byte but the terminator
    DS_HIGH,      // all 0xFF, drives the count past the top of the range
    DS_LOW        // all 0x00, each digit worth -48
  } digit_style_e;

  // Shape of one random reply
  typedef enum int {
    RK_GOOD,
    RK_BAD_HEADER,
    RK_CUT,       // frame abandoned part way, next frame start restarts it
    RK_NOISE      // loose bytes with a sprinkling of frame starts
  } reply_kind_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  encoder_reply_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the parser's own registers
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] m_pos   = '0;
  phase_t           m_phase = PH_IDLE;
  bit               m_neg1  = 1'b0;
  bit               m_neg2  = 1'b0;
  longint           m_acc1  = 0;
  longint           m_acc2  = 0;
  int               m_ndig  = 0;

  out_item_t expected_counts[$];   // results still owed by the block, oldest first
  int        mismatch_count = 0;
  int        frame_items    = 0;   // bytes of the random frames sent, frame start included
  bit        quiet          = 1'b0; // both sides run flat out while set
  int        hold_cycles    = 0;   // one-off long stall request for the result side

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_LIMIT)
      $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [31:0] clamp_count(input longint acc, input bit neg);
    longint v;
    v = neg ? -acc : acc;
    if (v > COUNT_MAX) return 32'h7FFF_FFFF;
    if (v < COUNT_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Advance the predicted parser by one accepted byte; queue any result it owes.
  // Any byte that is not the terminator is folded in as a digit (value byte-48),
  // so CR in the first number or ':' in the second are plain digits here.
  function automatic void step_reply_parser(input in_item_t item);
    out_item_t  res;
    logic [7:0] b;
    bit         in_first;
    bit         in_second;
    bit         done;
    b         = item.rx_byte;
    in_first  = 1'b0;
    in_second = 1'b0;
    done      = 1'b0;
    res       = '0;
    if (item.frame_start) begin
      // frame start always wins, even mid-frame: old frame dropped silently
      m_pos   = '0;
      m_neg1  = 1'b0;
      m_neg2  = 1'b0;
      m_acc1  = 0;
      m_acc2  = 0;
      m_ndig  = 0;
      m_phase = PH_HEADER;
      return;
    end
    case (m_phase)
      PH_HEADER: begin
        m_pos = m_pos + 1'b1;
        if (m_pos == HDR_EQ_POS) begin
          if (b != CH_EQUAL) begin
            res.status = ST_BAD_HEADER;
            done       = 1'b1;
          end else begin
            m_phase = PH_SIGN1;
            m_ndig  = 0;
          end
        end
      end
      PH_SIGN1: begin
        m_pos    = SIGN1_POS;
        m_phase  = PH_DIGITS1;
        m_neg1   = (b == CH_MINUS);
        in_first = !m_neg1;
      end
      PH_DIGITS1: in_first = 1'b1;
      PH_SIGN2: begin
        m_phase   = PH_DIGITS2;
        m_neg2    = (b == CH_MINUS);
        in_second = !m_neg2;
      end
      PH_DIGITS2: in_second = 1'b1;
      default: m_phase = PH_IDLE;   // idle bytes are dropped
    endcase
    if (in_first) begin
      if (b == CH_COLON) begin
        m_phase = PH_SIGN2;
        m_ndig  = 0;
      end else if (m_ndig >= DIGIT_LIMIT) begin
        res.status = ST_TOO_MANY;
        done       = 1'b1;
      end else begin
        m_acc1 = m_acc1 * 10 + longint'(b) - longint'(CH_ZERO);
        m_ndig++;
      end
    end
    if (in_second) begin
      if (b == CH_CR) begin
        res.first_count  = clamp_count(m_acc1, m_neg1);
        res.second_count = clamp_count(m_acc2, m_neg2);
        res.status       = ST_OK;
        done             = 1'b1;
      end else if (m_ndig >= DIGIT_LIMIT) begin
        res.status = ST_TOO_MANY;
        done       = 1'b1;
      end else begin
        m_acc2 = m_acc2 * 10 + longint'(b) - longint'(CH_ZERO);
        m_ndig++;
      end
    end
    if (done) begin
      expected_counts.push_back(res);
      m_phase = PH_IDLE;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: result transfers are checked before the same edge's input transfer
  // is predicted, as a result can never belong to a byte taken on that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d status %0d",
                                  out_data.first_count, out_data.second_count,
                                  out_data.status));
      end else begin
        want = expected_counts.pop_front();
        if (out_data.first_count !== want.first_count)
          report_mismatch($sformatf("first_count got %0d want %0d",
                                    out_data.first_count, want.first_count));
        if (out_data.second_count !== want.second_count)
          report_mismatch($sformatf("second_count got %0d want %0d",
                                    out_data.second_count, want.second_count));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
      end
    end
    if (rst_n && in_valid && !in_stall)
      step_reply_parser(in_data);
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall before each transfer, or a long counted hold-off
  // when a test asks for one. Drives out_stall from time zero.
  // ---------------------------------------------------------------------------
  always begin : result_sink
    int pause;
    if (hold_cycles > 0) begin
      pause       = hold_cycles;
      hold_cycles = 0;
    end else if (quiet) begin
      pause = 0;
    end else begin
      pause = $urandom_range(0, 4);
    end
    if (pause > 0) begin
      out_stall <= 1'b1;
      repeat (pause) @(posedge clk);
    end
    out_stall <= 1'b0;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------

  // One byte transfer, after a random gap; returns on the edge that takes it
  task automatic send_item(input logic [7:0] b, input logic fs);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_start: fs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Byte 0 carries the frame start mark (its value is don't-care), body follows
  task automatic send_reply(input logic [7:0] body[$]);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    foreach (body[i]) send_item(body[i], 1'b0);
  endtask

  // Hold the input side until every owed result has arrived, then let the
  // two-stage pipe empty of bytes that owe nothing
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Optional sign, digits, terminator
  task automatic add_number(ref logic [7:0] q[$], input logic [7:0] term,
                            input digit_style_e style);
    int         n;
    logic [7:0] b;
    if (style == DS_HIGH || style == DS_LOW)
      n = DIGIT_LIMIT;
    else if ($urandom_range(0, 19) == 0)
      n = DIGIT_LIMIT + 1;   // one digit too many
    else
      n = $urandom_range(0, DIGIT_LIMIT);
    if ($urandom_range(0, 1)) q.push_back(CH_MINUS);
    for (int i = 0; i < n; i++) begin
      case (style)
        DS_DECIMAL: b = CH_ZERO + 8'($urandom_range(0, 9));
        DS_HIGH:    b = 8'hFF;
        DS_LOW:     b = 8'h00;
        default: begin
          do b = 8'($urandom_range(0, 255)); while (b == term);
        end
      endcase
      q.push_back(b);
    end
    q.push_back(term);
  endtask

  task automatic send_random_reply();
    logic [7:0]   body[$];
    logic [7:0]   b;
    reply_kind_e  kind;
    digit_style_e style;
    int           pick;
    int           keep;
    pick = $urandom_range(0, 99);
    kind = pick < 70 ? RK_GOOD : pick < 80 ? RK_BAD_HEADER : pick < 90 ? RK_CUT : RK_NOISE;
    if (kind == RK_NOISE) begin
      repeat ($urandom_range(1, 8))
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      return;
    end
    repeat (3) body.push_back(8'($urandom_range(0, 255)));
    if (kind == RK_BAD_HEADER) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_EQUAL);
      body.push_back(b);
    end else begin
      body.push_back(CH_EQUAL);
      pick  = $urandom_range(0, 99);
      style = pick < 75 ? DS_DECIMAL : pick < 89 ? DS_ANY : pick < 95 ? DS_HIGH : DS_LOW;
      add_number(body, CH_COLON, style);
      add_number(body, CH_CR, style);
      if (kind == RK_CUT) begin
        keep = $urandom_range(1, body.size() - 1);
        while (body.size() > keep) void'(body.pop_back());
      end
    end
    send_reply(body);
    frame_items += body.size() + 1;
    // trailing bytes after a finished frame land on an idle parser
    if (kind == RK_GOOD && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes before any frame start are ignored
  task automatic test_idle_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    wait_results_drained();
  endtask

  // Byte 4 not '=' gives the header error with zero counts
  task automatic test_bad_header();
    logic [7:0] body[$];
    body = {8'hFF, 8'h00, 8'hA5, CH_COLON};
    send_reply(body);
    wait_results_drained();
  endtask

  // Frame start mid-frame restarts; the new frame has two empty numbers
  task automatic test_restart_empty();
    logic [7:0] body[$];
    send_item(8'h5A, 1'b1);
    send_item(CH_EQUAL, 1'b0);
    body = {8'h01, 8'h80, 8'h7F, CH_EQUAL, CH_COLON, CH_CR};
    send_reply(body);
    wait_results_drained();
  endtask

  // CR and a stray '-' inside the first number, ':' inside the second,
  // only the second number signed: expect -353 and -10
  task automatic test_non_digit_bytes();
    logic [7:0] body[$];
    body = {8'h30, 8'h31, 8'h32, CH_EQUAL, CH_CR, CH_MINUS, CH_COLON,
            CH_MINUS, CH_COLON, CH_CR};
    send_reply(body);
    wait_results_drained();
  endtask

  // Tenth digit of one number gives the overflow error; the CR after it is idle
  task automatic test_digit_overflow();
    logic [7:0] body[$];
    body = {8'h00, 8'h00, 8'h00, CH_EQUAL, CH_MINUS};
    repeat (DIGIT_LIMIT + 1) body.push_back(CH_ZERO + 8'd9);
    body.push_back(CH_CR);
    send_reply(body);
    wait_results_drained();
  endtask

  // Mostly well-formed replies with random content, plus broken ones and noise.
  // Runs flat out now and then, and pauses for a full drain every so often.
  task automatic test_random_replies();
    int frames;
    frames = 0;
    while (frame_items < FRAME_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      send_random_reply();
      frames++;
      if (frames % 20 == 0) wait_results_drained();
    end
    quiet = 1'b0;
    wait_results_drained();
  endtask

  // Result side holds off for a long stretch while short frames keep coming,
  // so both pipe registers fill and the input side has to stall
  task automatic test_backpressure();
    logic [7:0] body[$];
    body = {8'hC3, 8'h3C, 8'h99, CH_EQUAL, CH_ZERO + 8'd7, CH_COLON, CH_MINUS,
            CH_ZERO + 8'd2, CH_CR};
    quiet       = 1'b1;
    hold_cycles = 80;
    repeat (12) send_reply(body);
    quiet = 1'b0;
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_bad_header();
    test_restart_empty();
    test_non_digit_bytes();
    test_digit_overflow();
    test_backpressure();
    test_random_replies();

    // final drain, bounded in case the block has gone quiet
    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DRAIN_LIMIT && expected_counts.size() > 0; i++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_counts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));

    if (mismatch_count == 0) begin
      $display("encoder_reply_parser regression: pass");
    end else begin
      $display("encoder_reply_parser regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("encoder_reply_parser regression: fail");
    $finish;
  end

endmodule
